FILE: hdl/cct_led_dimmer_with_fade_core_defines.svh
// assertion macros for the cct led dimmer core
`ifndef CCT_LED_DIMMER_WITH_FADE_CORE_DEFINES_SVH
`define CCT_LED_DIMMER_WITH_FADE_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define CLD_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cld_pkg.sv
`default_nettype none

package cld_pkg;

    typedef logic [6:0] t_pct;

    typedef struct packed {
        logic hit;
        t_pct tone;
        t_pct bright;
    } t_preset;

    localparam logic [3:0] MODE_TICK       = 4'd0;
    localparam logic [3:0] MODE_ON         = 4'd1;
    localparam logic [3:0] MODE_OFF        = 4'd2;
    localparam logic [3:0] MODE_SET_BRIGHT = 4'd3;
    localparam logic [3:0] MODE_BRIGHT_UP  = 4'd4;
    localparam logic [3:0] MODE_BRIGHT_DN  = 4'd5;
    localparam logic [3:0] MODE_SET_TONE   = 4'd6;
    localparam logic [3:0] MODE_TONE_UP    = 4'd7;
    localparam logic [3:0] MODE_TONE_DN    = 4'd8;
    localparam logic [3:0] MODE_PRESET     = 4'd9;

    localparam t_pct PCT_MAX     = 7'd100;
    localparam t_pct PCT_HALF    = 7'd50;
    localparam t_pct BRIGHT_STEP = 7'd5;
    localparam t_pct BRIGHT_MIN  = 7'd10;
    localparam t_pct TONE_STEP   = 7'd10;
    localparam int   NEAR_DIST   = 50;

    localparam logic [1:0] WAIT_FAST = 2'd0;
    localparam logic [1:0] WAIT_SLOW = 2'd2;

    // target = floor(b * part * DUTY_MAX / 5000) via reciprocal multiply
    localparam int DIV_DEN     = 5000;
    localparam int RECIP_SHIFT = 26;

    localparam int GROUP_W     = 8;
    localparam int MODE_W      = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_DUTY_W  = 10;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_ON_BIT   = 20;
    localparam int OUT_FADE_BIT = 21;
    localparam int OUT_ACK_BIT  = 22;

    function automatic t_pct sat_pct(input logic [7:0] v);
        return (v > 8'(PCT_MAX)) ? PCT_MAX : v[6:0];
    endfunction

    function automatic t_pct bright_step(input t_pct b, input logic up);
        t_pct r;
        if (up) begin
            r = (b >= PCT_MAX - BRIGHT_STEP) ? PCT_MAX : b + BRIGHT_STEP;
        end else begin
            r = (b >= BRIGHT_MIN + BRIGHT_STEP) ? b - BRIGHT_STEP : BRIGHT_MIN;
        end
        return r;
    endfunction

    function automatic t_preset preset_lookup(input logic [7:0] sel);
        t_preset p;
        p = '{hit: 1'b1, tone: PCT_HALF, bright: PCT_MAX};
        case (sel)
            8'd0: p.tone = 7'd0;
            8'd1: p.tone = PCT_HALF;
            8'd2: p.tone = PCT_MAX;
            8'd3: p.bright = PCT_HALF;
            8'd4: p.bright = 7'd30;
            8'd5: p.bright = BRIGHT_MIN;
            default: p.hit = 1'b0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cld_target.sv
`default_nettype none

module cld_target #(
    parameter int DUTY_MAX = 1023
) (
    input  cld_pkg::t_pct                      i_bright,
    input  cld_pkg::t_pct                      i_tone,
    output logic [$clog2(DUTY_MAX+1)-1:0]      o_warm,
    output logic [$clog2(DUTY_MAX+1)-1:0]      o_cool
);
    import cld_pkg::*;

    localparam int DW = $clog2(DUTY_MAX + 1);
    localparam logic [63:0] RECIP =
        ((64'(DUTY_MAX) << RECIP_SHIFT) + 64'(DIV_DEN - 1)) / 64'(DIV_DEN);
    localparam int MW = $clog2(RECIP + 64'd1);
    localparam int TW = MW + 7;
    localparam int PW = TW + 7;
    localparam int QW = PW - RECIP_SHIFT;

    // part * reciprocal for every percent value
    logic [TW-1:0] w_part_tab [0:PCT_MAX];

    for (genvar gi = 0; gi <= int'(PCT_MAX); gi++) begin : g_tab
        assign w_part_tab[gi] = TW'(gi) * TW'(RECIP);
    end

    t_pct          w_warm_part;
    logic [PW-1:0] w_warm_prod;
    logic [PW-1:0] w_cool_prod;
    logic [QW-1:0] w_warm_q;
    logic [QW-1:0] w_cool_q;

    assign w_warm_part = PCT_MAX - i_tone;
    assign w_warm_prod = PW'(i_bright) * PW'(w_part_tab[w_warm_part]);
    assign w_cool_prod = PW'(i_bright) * PW'(w_part_tab[i_tone]);
    assign w_warm_q    = w_warm_prod[PW-1:RECIP_SHIFT];
    assign w_cool_q    = w_cool_prod[PW-1:RECIP_SHIFT];

    assign o_warm = (w_warm_q > QW'(DUTY_MAX)) ? DW'(DUTY_MAX) : w_warm_q[DW-1:0];
    assign o_cool = (w_cool_q > QW'(DUTY_MAX)) ? DW'(DUTY_MAX) : w_cool_q[DW-1:0];

endmodule

`default_nettype wire

FILE: hdl/cct_led_dimmer_with_fade_core.sv
`default_nettype none
`include "cct_led_dimmer_with_fade_core_defines.svh"

// Two-channel warm/cool LED dimmer with fading. Each input item is a tick
// (tuser mode 0) or a command addressed by its group byte; commands whose group
// differs from the device group register are ignored. Every item yields one
// result item with both current duties, the on flag, the fading flag and an
// acknowledge for on/off commands. An item passes an input register and then a
// result register, and one item is taken in every clock while the result side
// keeps up. The whole state update, including the two target multiplies of the
// scaling unit, sits between those two registers. DUTY_MAX sets the internal
// duty width; the duty fields on the result side carry its low ten bits.
module cct_led_dimmer_with_fade_core #(
    parameter int DUTY_MAX = 1023
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cld_pkg::GROUP_W-1:0]          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // group [7:0], value [15:8]
    input  logic [cld_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // mode [3:0]
    input  logic [cld_pkg::MODE_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // warm_duty [9:0], cool_duty [19:10], lamp_on [20], fading [21],
    // acknowledged [22], zero [23]
    output logic [cld_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import cld_pkg::*;

    localparam int DW = $clog2(DUTY_MAX + 1);

    logic [GROUP_W-1:0] r_group_cfg;

    logic               r_in_valid;
    logic [MODE_W-1:0]  r_in_mode;
    logic [7:0]         r_in_group;
    logic [7:0]         r_in_value;

    t_pct               r_brt, n_brt;
    t_pct               r_tone, n_tone;
    logic [DW-1:0]      r_warm_tgt, n_warm_tgt;
    logic [DW-1:0]      r_cool_tgt, n_cool_tgt;
    logic [DW-1:0]      r_warm_now, n_warm_now;
    logic [DW-1:0]      r_cool_now, n_cool_now;
    logic [1:0]         r_wait_lim, n_wait_lim;
    logic [1:0]         r_wait_cnt, n_wait_cnt;
    logic               r_fading, n_fading;
    logic               r_on, n_on;
    logic               n_ack;

    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic          w_advance;
    logic          w_take;
    logic          w_cmd_ok;
    logic [DW-1:0] w_warm_dist;
    logic [DW-1:0] w_cool_dist;
    logic          w_near_warm;
    logic          w_near_cool;
    logic [DW-1:0] w_calc_warm;
    logic [DW-1:0] w_calc_cool;
    t_preset       w_preset;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take        = r_in_valid && w_advance;

    assign w_cmd_ok = (r_in_mode != MODE_TICK) && (r_in_mode <= MODE_PRESET)
                   && (r_in_group == r_group_cfg);

    assign w_warm_dist = (r_warm_tgt > r_warm_now) ? r_warm_tgt - r_warm_now
                                                   : r_warm_now - r_warm_tgt;
    assign w_cool_dist = (r_cool_tgt > r_cool_now) ? r_cool_tgt - r_cool_now
                                                   : r_cool_now - r_cool_tgt;
    assign w_near_warm = (r_warm_tgt != r_warm_now) && (w_warm_dist < DW'(NEAR_DIST));
    assign w_near_cool = (r_cool_tgt != r_cool_now) && (w_cool_dist < DW'(NEAR_DIST));

    assign w_preset = preset_lookup(r_in_value);

    // brightness and tone update
    always_comb begin
        t_pct v_b1;
        logic v_up;
        v_up   = (r_in_mode == MODE_BRIGHT_UP);
        v_b1   = (!r_fading || w_near_warm) ? bright_step(r_brt, v_up) : r_brt;
        n_brt  = r_brt;
        n_tone = r_tone;
        if (w_cmd_ok) begin
            case (r_in_mode)
                MODE_SET_BRIGHT: begin
                    n_brt = sat_pct(r_in_value);
                end
                MODE_BRIGHT_UP, MODE_BRIGHT_DN: begin
                    n_brt = (r_fading && w_near_cool) ? bright_step(v_b1, v_up) : v_b1;
                end
                MODE_SET_TONE: begin
                    n_tone = sat_pct(r_in_value);
                end
                MODE_TONE_UP: begin
                    if (!r_fading) begin
                        n_tone = sat_pct(8'(r_tone) + 8'(TONE_STEP));
                    end
                end
                MODE_TONE_DN: begin
                    if (!r_fading) begin
                        n_tone = (r_tone >= TONE_STEP + TONE_STEP) ? r_tone - TONE_STEP : 7'd0;
                    end
                end
                MODE_PRESET: begin
                    if (w_preset.hit) begin
                        n_tone = w_preset.tone;
                        n_brt  = w_preset.bright;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    cld_target #(
        .DUTY_MAX (DUTY_MAX)
    ) u_target (
        .i_bright (n_brt),
        .i_tone   (n_tone),
        .o_warm   (w_calc_warm),
        .o_cool   (w_calc_cool)
    );

    // duties, targets, fade timing and flags
    always_comb begin
        n_warm_tgt = r_warm_tgt;
        n_cool_tgt = r_cool_tgt;
        n_warm_now = r_warm_now;
        n_cool_now = r_cool_now;
        n_wait_lim = r_wait_lim;
        n_wait_cnt = r_wait_cnt;
        n_fading   = r_fading;
        n_on       = r_on;
        n_ack      = 1'b0;
        if (r_in_mode == MODE_TICK) begin
            if (r_wait_cnt >= r_wait_lim) begin
                n_wait_cnt = 2'd0;
                if (r_warm_tgt > r_warm_now) begin
                    n_warm_now = r_warm_now + DW'(1);
                end else if (r_warm_tgt < r_warm_now) begin
                    n_warm_now = r_warm_now - DW'(1);
                end
                if (r_cool_tgt > r_cool_now) begin
                    n_cool_now = r_cool_now + DW'(1);
                end else if (r_cool_tgt < r_cool_now) begin
                    n_cool_now = r_cool_now - DW'(1);
                end
                if (n_warm_now == r_warm_tgt && n_cool_now == r_cool_tgt) begin
                    n_fading = 1'b0;
                end
            end else begin
                n_wait_cnt = r_wait_cnt + 2'd1;
            end
        end else if (w_cmd_ok) begin
            n_fading = 1'b1;
            case (r_in_mode)
                MODE_ON, MODE_PRESET: begin
                    n_on       = 1'b1;
                    n_wait_lim = WAIT_FAST;
                    n_warm_tgt = w_calc_warm;
                    n_cool_tgt = w_calc_cool;
                    n_warm_now = w_calc_warm;
                    n_cool_now = w_calc_cool;
                    n_ack      = (r_in_mode == MODE_ON);
                end
                MODE_OFF: begin
                    n_on       = 1'b0;
                    n_wait_lim = WAIT_FAST;
                    n_warm_tgt = '0;
                    n_cool_tgt = '0;
                    n_warm_now = '0;
                    n_cool_now = '0;
                    n_ack      = 1'b1;
                end
                MODE_SET_BRIGHT, MODE_SET_TONE: begin
                    n_wait_lim = WAIT_FAST;
                    n_warm_tgt = w_calc_warm;
                    n_cool_tgt = w_calc_cool;
                end
                MODE_BRIGHT_UP, MODE_BRIGHT_DN: begin
                    n_wait_lim = WAIT_SLOW;
                    n_warm_tgt = w_calc_warm;
                    n_cool_tgt = w_calc_cool;
                end
                MODE_TONE_UP: begin
                    if (!r_fading) begin
                        if (r_tone < PCT_MAX) begin
                            n_wait_lim = WAIT_SLOW;
                        end
                        n_warm_tgt = w_calc_warm;
                        n_cool_tgt = w_calc_cool;
                    end
                end
                MODE_TONE_DN: begin
                    if (!r_fading) begin
                        if (r_tone >= TONE_STEP) begin
                            n_wait_lim = WAIT_SLOW;
                        end
                        n_warm_tgt = w_calc_warm;
                        n_cool_tgt = w_calc_cool;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_cfg <= '0;
        end else if (i_cfg_we) begin
            r_group_cfg <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode  <= s_axis_tuser;
            r_in_group <= s_axis_tdata[7:0];
            r_in_value <= s_axis_tdata[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brt      <= '0;
            r_tone     <= '0;
            r_warm_tgt <= '0;
            r_cool_tgt <= '0;
            r_warm_now <= '0;
            r_cool_now <= '0;
            r_wait_lim <= '0;
            r_wait_cnt <= '0;
            r_fading   <= 1'b0;
            r_on       <= 1'b0;
        end else if (w_take) begin
            r_brt      <= n_brt;
            r_tone     <= n_tone;
            r_warm_tgt <= n_warm_tgt;
            r_cool_tgt <= n_cool_tgt;
            r_warm_now <= n_warm_now;
            r_cool_now <= n_cool_now;
            r_wait_lim <= n_wait_lim;
            r_wait_cnt <= n_wait_cnt;
            r_fading   <= n_fading;
            r_on       <= n_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {1'b0, n_ack, n_fading, n_on,
                           OUT_DUTY_W'(n_cool_now), OUT_DUTY_W'(n_warm_now)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `CLD_ASSERT(a_settled_when_idle, !r_fading, (r_warm_now == r_warm_tgt) && (r_cool_now == r_cool_tgt), "idle with duties off target")
    `CLD_ASSERT(a_ack_sets_fading, r_out_valid && r_out_data[OUT_ACK_BIT], r_out_data[OUT_FADE_BIT], "acknowledged item without fading")
    `CLD_ASSERT(a_wait_cnt_range, 1'b1, r_wait_cnt != 2'd3, "tick counter out of range")
    `CLD_ASSERT(a_duty_range, 1'b1, (r_warm_now <= DW'(DUTY_MAX)) && (r_cool_now <= DW'(DUTY_MAX)), "duty above maximum")
    `CLD_ASSERT_NEXT(a_in_hold, r_in_valid && !w_advance, r_in_valid && $stable(r_in_mode), "stalled item lost")

endmodule

`default_nettype wire

FILE: tb/sv/cct_led_dimmer_with_fade_core_tb.sv
`default_nettype none

module cct_led_dimmer_with_fade_core_tb;
    import cld_pkg::*;

    localparam int DUTY_MAX = 1023;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [7:0] SCRIPT_GROUP = 8'hA5;
    localparam logic [7:0] OTHER_GROUP = 8'h5A;
    localparam logic [3:0] MODE_UNUSED_HI = 4'hF;
    localparam logic [3:0] MODE_UNUSED_LO = 4'hA;

    typedef struct packed {
        logic [9:0] warm;
        logic [9:0] cool;
        logic       lamp_on;
        logic       fading;
        logic       ack;
    } t_lamp_out;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] grp;
        logic [7:0] val;
        logic       fixed;
        t_lamp_out  want;
    } t_script_row;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [GROUP_W-1:0]     i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // group [7:0], value [15:8]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // mode [3:0]
    logic [MODE_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // warm_duty [9:0], cool_duty [19:10], lamp_on [20], fading [21],
    // acknowledged [22], zero [23]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    cct_led_dimmer_with_fade_core #(
        .DUTY_MAX(DUTY_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predicted dimmer state
    logic [7:0] group_reg = '0;
    t_pct       bright = '0;
    t_pct       tone = '0;
    logic [9:0] warm_tgt = '0;
    logic [9:0] cool_tgt = '0;
    logic [9:0] warm_now = '0;
    logic [9:0] cool_now = '0;
    logic [1:0] wait_lim = '0;
    logic [1:0] wait_cnt = '0;
    logic       fade_flag = 1'b0;
    logic       on_flag = 1'b0;

    t_lamp_out pending_lamp_out [$];
    int        mismatches = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    int        quiet_cycles = 0;

    t_script_row script [0:24] = '{
        '{MODE_TICK,       8'h00,        8'h00, 1'b1, '{10'd0,    10'd0,    1'b0, 1'b0, 1'b0}},
        '{MODE_ON,         SCRIPT_GROUP, 8'h00, 1'b1, '{10'd0,    10'd0,    1'b1, 1'b1, 1'b1}},
        '{MODE_TICK,       8'h00,        8'h00, 1'b1, '{10'd0,    10'd0,    1'b1, 1'b0, 1'b0}},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd0,  1'b1, '{10'd1023, 10'd0,    1'b1, 1'b1, 1'b0}},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd2,  1'b1, '{10'd0,    10'd1023, 1'b1, 1'b1, 1'b0}},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd1,  1'b1, '{10'd1023, 10'd1023, 1'b1, 1'b1, 1'b0}},
        '{MODE_OFF,        OTHER_GROUP,  8'h00, 1'b0, '0},
        '{MODE_OFF,        SCRIPT_GROUP, 8'h00, 1'b1, '{10'd0,    10'd0,    1'b0, 1'b1, 1'b1}},
        '{MODE_UNUSED_HI,  SCRIPT_GROUP, 8'hFF, 1'b0, '0},
        '{MODE_SET_BRIGHT, SCRIPT_GROUP, 8'hFF, 1'b0, '0},
        '{MODE_SET_TONE,   SCRIPT_GROUP, 8'hC8, 1'b0, '0},
        '{MODE_TICK,       8'hFF,        8'hFF, 1'b0, '0},
        '{MODE_BRIGHT_UP,  SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_BRIGHT_DN,  SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_TONE_UP,    SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'hFF, 1'b0, '0},
        '{MODE_TICK,       8'h00,        8'h00, 1'b0, '0},
        '{MODE_TONE_DN,    SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd5,  1'b0, '0},
        '{MODE_TICK,       8'h00,        8'h00, 1'b0, '0},
        '{MODE_BRIGHT_DN,  SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd3,  1'b0, '0},
        '{MODE_PRESET,     SCRIPT_GROUP, 8'd4,  1'b0, '0},
        '{MODE_ON,         SCRIPT_GROUP, 8'h00, 1'b0, '0},
        '{MODE_UNUSED_LO,  SCRIPT_GROUP, 8'h00, 1'b0, '0}
    };

    function automatic logic [9:0] duty_for(input t_pct b, input int part);
        int v;
        v = int'(b) * DUTY_MAX * part / 5000;
        return (v > DUTY_MAX) ? 10'(DUTY_MAX) : 10'(v);
    endfunction

    function automatic void retarget();
        warm_tgt = duty_for(bright, int'(PCT_MAX) - int'(tone));
        cool_tgt = duty_for(bright, int'(tone));
    endfunction

    function automatic logic [9:0] step_duty(input logic [9:0] now, input logic [9:0] tgt);
        if (tgt > now) return now + 10'd1;
        if (tgt < now) return now - 10'd1;
        return now;
    endfunction

    function automatic logic near_tgt(input logic [9:0] tgt, input logic [9:0] now);
        int d;
        d = (tgt > now) ? int'(tgt) - int'(now) : int'(now) - int'(tgt);
        return (d != 0) && (d < NEAR_DIST);
    endfunction

    function automatic t_lamp_out advance_dimmer(input logic [3:0] mode, input logic [7:0] grp,
                                                 input logic [7:0] val);
        t_lamp_out r;
        logic      ack;
        int        nudges;
        ack = 1'b0;
        nudges = 0;
        if (mode == MODE_TICK) begin
            if (wait_cnt >= wait_lim) begin
                wait_cnt = '0;
                warm_now = step_duty(warm_now, warm_tgt);
                cool_now = step_duty(cool_now, cool_tgt);
                if (warm_now == warm_tgt && cool_now == cool_tgt) fade_flag = 1'b0;
            end else begin
                wait_cnt = wait_cnt + 2'd1;
            end
        end else if (mode <= MODE_PRESET && grp == group_reg) begin
            case (mode)
                MODE_ON: begin
                    on_flag = 1'b1;
                    wait_lim = WAIT_FAST;
                    retarget();
                    warm_now = warm_tgt;
                    cool_now = cool_tgt;
                    ack = 1'b1;
                end
                MODE_OFF: begin
                    on_flag = 1'b0;
                    wait_lim = WAIT_FAST;
                    warm_tgt = '0;
                    cool_tgt = '0;
                    warm_now = '0;
                    cool_now = '0;
                    ack = 1'b1;
                end
                MODE_SET_BRIGHT, MODE_SET_TONE: begin
                    if (mode == MODE_SET_BRIGHT) bright = (val > 8'd100) ? PCT_MAX : val[6:0];
                    else tone = (val > 8'd100) ? PCT_MAX : val[6:0];
                    wait_lim = WAIT_FAST;
                    retarget();
                end
                MODE_BRIGHT_UP, MODE_BRIGHT_DN: begin
                    if (!fade_flag) begin
                        nudges = 1;
                    end else begin
                        if (near_tgt(warm_tgt, warm_now)) nudges++;
                        if (near_tgt(cool_tgt, cool_now)) nudges++;
                    end
                    repeat (nudges) begin
                        if (mode == MODE_BRIGHT_UP) bright = (bright + 7'd5 > 7'd100) ? PCT_MAX
                                                                                       : bright + 7'd5;
                        else bright = (bright >= 7'd15) ? bright - 7'd5 : BRIGHT_MIN;
                    end
                    wait_lim = WAIT_SLOW;
                    retarget();
                end
                MODE_TONE_UP: begin
                    if (!fade_flag) begin
                        if (tone < 7'd100) begin
                            wait_lim = WAIT_SLOW;
                            tone = (tone + 7'd10 > 7'd100) ? PCT_MAX : tone + 7'd10;
                        end
                        retarget();
                    end
                end
                MODE_TONE_DN: begin
                    if (!fade_flag) begin
                        if (tone >= 7'd10) begin
                            wait_lim = WAIT_SLOW;
                            tone = tone - 7'd10;
                            if (tone < 7'd10) tone = '0;
                        end else begin
                            tone = '0;
                        end
                        retarget();
                    end
                end
                default: begin
                    wait_lim = WAIT_FAST;
                    case (val)
                        8'd0: begin tone = 7'd0;   bright = 7'd100; end
                        8'd1: begin tone = 7'd50;  bright = 7'd100; end
                        8'd2: begin tone = 7'd100; bright = 7'd100; end
                        8'd3: begin tone = 7'd50;  bright = 7'd50;  end
                        8'd4: begin tone = 7'd50;  bright = 7'd30;  end
                        8'd5: begin tone = 7'd50;  bright = 7'd10;  end
                        default: ;
                    endcase
                    retarget();
                    warm_now = warm_tgt;
                    cool_now = cool_tgt;
                    on_flag = 1'b1;
                end
            endcase
            fade_flag = 1'b1;
        end
        r.warm = warm_now;
        r.cool = cool_now;
        r.lamp_on = on_flag;
        r.fading = fade_flag;
        r.ack = ack;
        return r;
    endfunction

    task automatic put_item(input logic [3:0] mode, input logic [7:0] grp, input logic [7:0] val,
                            input logic fixed, input t_lamp_out want);
        t_lamp_out predicted;
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {val, grp};
        s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = advance_dimmer(mode, grp, val);
        pending_lamp_out.push_back(fixed ? want : predicted);
    endtask

    task automatic write_group(input logic [7:0] grp);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= grp;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        group_reg = grp;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_lamp_out.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        logic [3:0] md;
        logic [7:0] gp;
        logic [7:0] vl;
        int         pick;
        repeat (count) begin
            pick = $urandom_range(99);
            gp = 8'($urandom);
            if (pick < 65) begin
                md = MODE_TICK;
            end else if (pick < 97) begin
                md = 4'($urandom_range(MODE_ON, MODE_PRESET));
                if ($urandom_range(9) != 0) gp = group_reg;
            end else begin
                md = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                if ($urandom_range(1) != 0) gp = group_reg;
            end
            case (md)
                MODE_PRESET:
                    vl = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(5));
                MODE_SET_BRIGHT, MODE_SET_TONE:
                    vl = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(100));
                default:
                    vl = 8'($urandom);
            endcase
            put_item(md, gp, vl, 1'b0, '0);
        end
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin : result_check
        t_lamp_out got;
        t_lamp_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.warm = m_axis_tdata[OUT_DUTY_W-1:0];
            got.cool = m_axis_tdata[2*OUT_DUTY_W-1:OUT_DUTY_W];
            got.lamp_on = m_axis_tdata[OUT_ON_BIT];
            got.fading = m_axis_tdata[OUT_FADE_BIT];
            got.ack = m_axis_tdata[OUT_ACK_BIT];
            if (pending_lamp_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: warm=%0d cool=%0d lamp=%0b fade=%0b ack=%0b",
                             got.warm, got.cool, got.lamp_on, got.fading, got.ack);
            end else begin
                want = pending_lamp_out.pop_front();
                if (got.warm != want.warm || got.cool != want.cool ||
                    got.lamp_on != want.lamp_on || got.fading != want.fading ||
                    got.ack != want.ack) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: expected warm=%0d cool=%0d lamp=%0b fade=%0b ack=%0b",
                               want.warm, want.cool, want.lamp_on, want.fading, want.ack);
                        $display(" got warm=%0d cool=%0d lamp=%0b fade=%0b ack=%0b",
                                 got.warm, got.cool, got.lamp_on, got.fading, got.ack);
                    end
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_group(SCRIPT_GROUP);
        for (k = 0; k < 25; k++)
            put_item(script[k].mode, script[k].grp, script[k].val, script[k].fixed, script[k].want);
        settle();

        write_group(8'hFF);
        src_idle_pct = 20;
        snk_idle_pct = 78;
        run_random(560);
        settle();

        write_group(8'h00);
        src_idle_pct = 78;
        snk_idle_pct = 20;
        run_random(560);
        settle();

        write_group(8'($urandom_range(1, 254)));
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(560);
        settle();

        if (mismatches == 0 && pending_lamp_out.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
